/* hw/rtl/stack_with_middle_access_assert.svh */
// Assertion macros for the stack with middle access checker.
`ifndef STACK_WITH_MIDDLE_ACCESS_ASSERT_SVH
`define STACK_WITH_MIDDLE_ACCESS_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SWMA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stack_with_middle_access check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SWMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stack_with_middle_access check failed");

`endif

/* hw/rtl/swma_pkg.sv */
// Shared codes and control types for the stack with middle access.
`default_nettype none
package swma_pkg;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_DELMID = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] RD_TOP   = 2'd0;
    localparam logic [1:0] RD_MID   = 2'd1;
    localparam logic [1:0] RD_NEXT1 = 2'd2;
    localparam logic [1:0] RD_NEXT2 = 2'd3;

    typedef struct packed {
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_push;
        logic       wr_shift;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       idx_load;
        logic       idx_inc;
        logic       rem_clr;
        logic       rem_cap;
        logic       out_load;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic shift_first;
        logic shift_more;
    } t_dp_stat;

endpackage
`default_nettype wire

/* hw/rtl/swma_ctrl.sv */
// Sequencer for push, pop, middle deletion and middle lookup.
`default_nettype none
module swma_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [1:0]          i_command,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    input  swma_pkg::t_dp_stat  i_stat,
    output swma_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REM   = 3'd1;
    localparam logic [2:0] S_DREM  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_MID   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_status;
    logic [1:0] n_status;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;

    assign o_in_stall  = (r_state != S_IDLE) | ~i_rst_n;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.rem_clr = 1'b1;
                    n_status      = swma_pkg::ST_OK;
                    n_state       = S_MID;
                    unique case (i_command)
                        swma_pkg::CMD_PUSH: begin
                            if (i_stat.full) begin
                                n_status = swma_pkg::ST_FULL;
                            end else begin
                                o_cmd.wr_push = 1'b1;
                                o_cmd.cnt_inc = 1'b1;
                            end
                        end
                        swma_pkg::CMD_POP: begin
                            if (i_stat.empty) begin
                                n_status = swma_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.rd_en   = 1'b1;
                                o_cmd.rd_sel  = swma_pkg::RD_TOP;
                                o_cmd.cnt_dec = 1'b1;
                                n_state       = S_REM;
                            end
                        end
                        swma_pkg::CMD_DELMID: begin
                            if (i_stat.empty) begin
                                n_status = swma_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.rd_en    = 1'b1;
                                o_cmd.rd_sel   = swma_pkg::RD_MID;
                                o_cmd.idx_load = 1'b1;
                                n_state        = S_DREM;
                            end
                        end
                        swma_pkg::CMD_QUERY: begin
                            n_state = S_MID;
                        end
                    endcase
                end
            end
            S_REM: begin
                o_cmd.rem_cap = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = swma_pkg::RD_MID;
                n_state       = S_OUT;
            end
            S_DREM: begin
                o_cmd.rem_cap = 1'b1;
                if (i_stat.shift_first) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = swma_pkg::RD_NEXT1;
                    n_state      = S_SHIFT;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_MID;
                end
            end
            S_SHIFT: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                if (i_stat.shift_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = swma_pkg::RD_NEXT2;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_MID;
                end
            end
            S_MID: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = swma_pkg::RD_MID;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.status = r_status;
        n_out_valid  = o_cmd.out_load | (r_out_valid & i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

endmodule
`default_nettype wire

/* hw/rtl/swma_dp.sv */
// Entry memory, count, shift index and result registers.
`default_nettype none
module swma_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  swma_pkg::t_dp_cmd                     i_cmd,
    output swma_pkg::t_dp_stat                    o_stat,
    input  wire  signed [DATA_WIDTH-1:0]          i_push_value,
    output logic [1:0]                            o_status,
    output logic signed [DATA_WIDTH-1:0]          o_removed_value,
    output logic signed [DATA_WIDTH-1:0]          o_middle_value,
    output logic                                  o_middle_valid,
    output logic [$clog2(DEPTH+1)-1:0]            o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [DATA_WIDTH-1:0] r_removed;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_idx;
    logic [1:0]            r_o_status;
    logic [DATA_WIDTH-1:0] r_o_removed;
    logic [DATA_WIDTH-1:0] r_o_middle;
    logic                  r_o_mid_valid;
    logic [CW-1:0]         r_o_occ;

    logic [AW-1:0]         w_mid;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic                  w_wr_en;

    assign w_mid = AW'(r_count >> 1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            swma_pkg::RD_TOP:   w_rd_addr = AW'(r_count - CW'(1));
            swma_pkg::RD_MID:   w_rd_addr = w_mid;
            swma_pkg::RD_NEXT1: w_rd_addr = r_idx + AW'(1);
            swma_pkg::RD_NEXT2: w_rd_addr = r_idx + AW'(2);
        endcase
    end

    assign w_wr_en   = i_cmd.wr_push | i_cmd.wr_shift;
    assign w_wr_addr = i_cmd.wr_push ? AW'(r_count) : r_idx;
    assign w_wr_data = i_cmd.wr_push ? i_push_value : r_rd_data;

    assign o_stat.empty       = (r_count == '0);
    assign o_stat.full        = (r_count == CW'(DEPTH));
    assign o_stat.shift_first = (CW'(r_idx) + CW'(1)) < r_count;
    assign o_stat.shift_more  = (CW'(r_idx) + CW'(2)) < r_count;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_load) begin
            r_idx <= w_mid;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.rem_clr) begin
            r_removed <= '0;
        end else if (i_cmd.rem_cap) begin
            r_removed <= r_rd_data;
        end
        if (i_cmd.out_load) begin
            r_o_status    <= i_cmd.status;
            r_o_removed   <= r_removed;
            r_o_middle    <= (r_count != '0) ? r_rd_data : '0;
            r_o_mid_valid <= (r_count != '0);
            r_o_occ       <= r_count;
        end
    end

    assign o_status        = r_o_status;
    assign o_removed_value = r_o_removed;
    assign o_middle_value  = r_o_middle;
    assign o_middle_valid  = r_o_mid_valid;
    assign o_occupancy     = r_o_occ;

endmodule
`default_nettype wire

/* hw/rtl/stack_with_middle_access.sv */
// Push, query and rejected beats go through the middle read state, a pop through the
// removed-entry capture state, then the output state registers the result and the next
// beat is taken once the sequencer is back in idle. Delete middle moves the entries
// above the middle down through the single write and single read port of the entry memory.
// Reset clears the sequencer, output valid and the entry count; stored entries are not
// cleared and there is no clearing pass.
`default_nettype none
module stack_with_middle_access #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [1:0]                     i_command,
    input  wire  signed [DATA_WIDTH-1:0]   i_push_value,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [1:0]                     o_status,
    output logic signed [DATA_WIDTH-1:0]   o_removed_value,
    output logic signed [DATA_WIDTH-1:0]   o_middle_value,
    output logic                           o_middle_valid,
    output logic [$clog2(DEPTH+1)-1:0]     o_occupancy
);

    swma_pkg::t_dp_cmd  w_cmd;
    swma_pkg::t_dp_stat w_stat;

    swma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    swma_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_push_value    (i_push_value),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_middle_value  (o_middle_value),
        .o_middle_valid  (o_middle_valid),
        .o_occupancy     (o_occupancy)
    );

endmodule
`default_nettype wire

/* hw/rtl/swma_checker.sv */
// Port-level checks for the stack with middle access, bound to the top level.
`default_nettype none
`include "stack_with_middle_access_assert.svh"
module swma_checker #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_out_valid,
    input wire                          i_out_stall,
    input wire [1:0]                    o_status,
    input wire [DATA_WIDTH-1:0]         o_removed_value,
    input wire [DATA_WIDTH-1:0]         o_middle_value,
    input wire                          o_middle_valid,
    input wire [$clog2(DEPTH+1)-1:0]    o_occupancy
);

    localparam int OW = $clog2(DEPTH + 1);

    `SWMA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_removed_value) && $stable(o_middle_value) && $stable(o_occupancy))
    `SWMA_ASSERT_NOW(a_mid_valid, o_out_valid, o_middle_valid == (o_occupancy != '0))
    `SWMA_ASSERT_NOW(a_mid_zero, o_out_valid && !o_middle_valid, o_middle_value == '0)
    `SWMA_ASSERT_NOW(a_err_no_removed, o_out_valid && (o_status != swma_pkg::ST_OK), o_removed_value == '0)
    `SWMA_ASSERT_NOW(a_occ_bound, o_out_valid, o_occupancy <= OW'(DEPTH))

endmodule

bind stack_with_middle_access swma_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_swma_checker (.*);
`default_nettype wire

/* test/stack_with_middle_access_check.sv */
// Checker for the stack with middle access: mirrors the stack and compares every result beat.
module stack_with_middle_access_check #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [1:0]                          i_command,
    input  logic signed [DATA_WIDTH-1:0]        i_push_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [1:0]                          i_status,
    input  logic signed [DATA_WIDTH-1:0]        i_removed_value,
    input  logic signed [DATA_WIDTH-1:0]        i_middle_value,
    input  logic                                i_middle_valid,
    input  logic [$clog2(DEPTH+1)-1:0]          i_occupancy,
    output int                                  o_fail_count,
    output int                                  o_waiting
);

    localparam int OCC_W = $clog2(DEPTH+1);

    typedef struct {
        logic [1:0]                   status;
        logic signed [DATA_WIDTH-1:0] removed;
        logic signed [DATA_WIDTH-1:0] middle;
        logic                         mid_valid;
        logic [OCC_W-1:0]             occupancy;
    } t_stack_result;

    logic signed [DATA_WIDTH-1:0] stack_words [DEPTH];
    int                           stack_fill;
    t_stack_result                expected_results [$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        o_fail_count++;
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic apply_command(input logic [1:0] cmd, input logic signed [DATA_WIDTH-1:0] word,
                                 output t_stack_result res);
        int mid;
        res.status  = swma_pkg::ST_OK;
        res.removed = '0;
        case (cmd)
            swma_pkg::CMD_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    res.status = swma_pkg::ST_FULL;
                end else begin
                    stack_words[stack_fill] = word;
                    stack_fill++;
                end
            end
            swma_pkg::CMD_POP: begin
                if (stack_fill == 0) begin
                    res.status = swma_pkg::ST_EMPTY;
                end else begin
                    stack_fill--;
                    res.removed = stack_words[stack_fill];
                end
            end
            swma_pkg::CMD_DELMID: begin
                if (stack_fill == 0) begin
                    res.status = swma_pkg::ST_EMPTY;
                end else begin
                    mid = stack_fill / 2;
                    res.removed = stack_words[mid];
                    for (int i = mid; i < stack_fill - 1; i++)
                        stack_words[i] = stack_words[i+1];
                    stack_fill--;
                end
            end
            default: ;
        endcase
        res.middle    = (stack_fill > 0) ? stack_words[stack_fill/2] : '0;
        res.mid_valid = (stack_fill > 0);
        res.occupancy = stack_fill[OCC_W-1:0];
    endtask

    always @(posedge i_clk) begin : watch
        t_stack_result want;
        if (!i_rst_n) begin
            stack_fill   = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 64'(i_status),
                                    64'(0));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", 64'(i_status), 64'(want.status));
                    compare_field("removed_value", 64'(i_removed_value),
                                  64'(want.removed));
                    compare_field("middle_value", 64'(i_middle_value), 64'(want.middle));
                    compare_field("middle_valid", 64'(i_middle_valid),
                                  64'(want.mid_valid));
                    compare_field("occupancy", 64'(i_occupancy), 64'(want.occupancy));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_command(i_command, i_push_value, want);
                expected_results.push_back(want);
            end
        end
        o_waiting = expected_results.size();
    end

endmodule

/* test/stack_with_middle_access_test.sv */
// Top of the stack with middle access testbench: clock, reset, command stimulus and verdict.
module stack_with_middle_access_test;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int RANDOM_BEATS = 1500;
    localparam int CYCLE_LIMIT  = 400000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    command;
    logic signed [DATA_WIDTH-1:0]  push_value;
    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    status;
    logic signed [DATA_WIDTH-1:0]  removed_value;
    logic signed [DATA_WIDTH-1:0]  middle_value;
    logic                          middle_valid;
    logic [$clog2(DEPTH+1)-1:0]    occupancy;
    int                            fail_count;
    int                            waiting;
    int                            cycle_count;
    bit                            steady;

    stack_with_middle_access #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (command),
        .i_push_value    (push_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_removed_value (removed_value),
        .o_middle_value  (middle_value),
        .o_middle_valid  (middle_valid),
        .o_occupancy     (occupancy)
    );

    stack_with_middle_access_check #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) stack_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_command       (command),
        .i_push_value    (push_value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (status),
        .i_removed_value (removed_value),
        .i_middle_value  (middle_value),
        .i_middle_valid  (middle_valid),
        .i_occupancy     (occupancy),
        .o_fail_count    (fail_count),
        .o_waiting       (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            out_stall = !steady && ($urandom_range(99) < 34);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [1:0] pick_command(input int mode);
        int r;
        r = $urandom_range(99);
        if (mode == 0)
            return (r < 65) ? swma_pkg::CMD_PUSH : (r < 78) ? swma_pkg::CMD_POP :
                   (r < 90) ? swma_pkg::CMD_DELMID : swma_pkg::CMD_QUERY;
        if (mode == 1)
            return (r < 20) ? swma_pkg::CMD_PUSH : (r < 55) ? swma_pkg::CMD_POP :
                   (r < 90) ? swma_pkg::CMD_DELMID : swma_pkg::CMD_QUERY;
        return 2'($urandom_range(3));
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $signed(32'($urandom_range(15))) - 8;
            default: return $urandom;
        endcase
    endfunction

    // drive one beat at the falling edge and hold it until accepted
    task automatic send_beat(input logic [1:0] cmd, input logic signed [DATA_WIDTH-1:0] word);
        while (!steady && $urandom_range(99) < 34) begin
            in_valid   = 1'b0;
            push_value = $urandom;
            @(negedge i_clk);
        end
        in_valid   = 1'b1;
        command    = cmd;
        push_value = word;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int mode;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        command    = swma_pkg::CMD_QUERY;
        push_value = '0;
        steady     = 1'b0;
        mode       = 2;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(swma_pkg::CMD_QUERY, 32'h0);
        send_beat(swma_pkg::CMD_POP, 32'h1234_5678);
        send_beat(swma_pkg::CMD_DELMID, -1);
        send_beat(swma_pkg::CMD_PUSH, 32'h7fff_ffff);
        send_beat(swma_pkg::CMD_DELMID, 32'h0);
        send_beat(swma_pkg::CMD_PUSH, 32'h8000_0000);
        send_beat(swma_pkg::CMD_PUSH, 32'hffff_ffff);
        send_beat(swma_pkg::CMD_PUSH, 32'h0000_0000);
        send_beat(swma_pkg::CMD_PUSH, 32'h5555_5555);
        send_beat(swma_pkg::CMD_PUSH, 32'haaaa_aaaa);
        send_beat(swma_pkg::CMD_PUSH, 32'h7fff_ffff);
        send_beat(swma_pkg::CMD_PUSH, 32'h0000_0001);
        for (int n = 0; n < 9; n++)
            send_beat(swma_pkg::CMD_PUSH, $urandom);
        send_beat(swma_pkg::CMD_PUSH, 32'h0bad_0bad);
        send_beat(swma_pkg::CMD_QUERY, $urandom);
        send_beat(swma_pkg::CMD_DELMID, $urandom);
        send_beat(swma_pkg::CMD_POP, $urandom);

        // alternate growing, shrinking and mixed bursts to hit full and empty often
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 20 == 0)
                mode = $urandom_range(2);
            steady = (n >= 600 && n < 800);
            send_beat(pick_command(mode), pick_word());
        end
        in_valid = 1'b0;
        steady   = 1'b0;

        wait (waiting == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/swma_pkg.sv
hw/rtl/swma_ctrl.sv
hw/rtl/swma_dp.sv
hw/rtl/stack_with_middle_access.sv
hw/rtl/swma_checker.sv
test/stack_with_middle_access_check.sv
test/stack_with_middle_access_test.sv
